// File: design/singly_linked_list_with_cursor_unit_macros.svh
// Assertion macros shared by the list unit RTL.
`ifndef SINGLY_LINKED_LIST_WITH_CURSOR_UNIT_MACROS_SVH
`define SINGLY_LINKED_LIST_WITH_CURSOR_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLLC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sllc assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define SLLC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sllc assertion failed");

`endif

// File: design/sllc_pkg.sv
// Shared constants and codes of the linked-list unit.
package sllc_pkg;

  localparam int NODES_DEF      = 64;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CMD_W          = 4;
  localparam int VALUE_W        = 32;
  localparam int STATUS_W       = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 4'd0,
    CMD_INS_HEAD  = 4'd1,
    CMD_CUR_HEAD  = 4'd2,
    CMD_RD_HEAD   = 4'd3,
    CMD_DEL_HEAD  = 4'd4,
    CMD_DEL_AFTER = 4'd5,
    CMD_INS_AFTER = 4'd6,
    CMD_RD_CUR    = 4'd7,
    CMD_WR_CUR    = 4'd8,
    CMD_ADVANCE   = 4'd9,
    CMD_QUERY     = 4'd10
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// File: design/sllc_in_if.sv
// Command channel: valid/ready with command and value.
interface sllc_in_if;
  logic                                valid;
  logic                                ready;
  logic [sllc_pkg::CMD_W-1:0]          cmd;
  logic signed [sllc_pkg::VALUE_W-1:0] value;

  modport source (output valid, cmd, value, input ready);
  modport sink   (input valid, cmd, value, output ready);
endinterface

// File: design/sllc_out_if.sv
// Result channel: valid/ready with read value, cursor flag and status.
interface sllc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [sllc_pkg::VALUE_W-1:0] read_value;
  logic                                is_active;
  logic [sllc_pkg::STATUS_W-1:0]       status;

  modport source (output valid, read_value, is_active, status, input ready);
  modport sink   (input valid, read_value, is_active, status, output ready);
endinterface

// File: design/sllc_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module sllc_ram #(
  parameter int DEPTH = sllc_pkg::NODES_DEF,
  parameter int WIDTH = sllc_pkg::DATA_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: design/singly_linked_list_with_cursor_unit.sv
// Commands: most finish in S_EXEC; delete/insert after cursor go on through S_STEP2 and S_STEP3,
// and clear walks the list from S_EXEC through S_CLR, one node freed per cycle while output is free.
// Throughput: one command at a time; the unit is back in S_IDLE, ready for the next, as the result
// word is registered, and S_EXEC and the states after it wait while an untaken result is held.
// Reset (rst_n, synchronous): list, cursor and free list empty, allocator at node 0.
// Node memories are not cleared; nodes are always written when allocated.
`include "singly_linked_list_with_cursor_unit_macros.svh"

module singly_linked_list_with_cursor_unit #(
  parameter int NODES      = sllc_pkg::NODES_DEF,
  parameter int DATA_WIDTH = sllc_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  sllc_in_if.sink    in_ch,
  sllc_out_if.source out_ch
);

  // Node index width holds the null code NODES; address width covers real nodes.
  localparam int IW = $clog2(NODES + 1);
  localparam int AW = $clog2(NODES);
  localparam int VW = sllc_pkg::VALUE_W;
  localparam logic [IW-1:0] NIL = IW'(NODES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,  // waiting for a command word
    S_EXEC  = 5'b00010,  // first read data back, main update
    S_STEP2 = 5'b00100,  // first link write of insert/delete after cursor
    S_STEP3 = 5'b01000,  // final link write of insert/delete after cursor
    S_CLR   = 5'b10000   // clear walk, one node per cycle while the output is free
  } state_t;

  state_t                  st_r, st_nxt;
  sllc_pkg::cmd_t          cmd_r, cmd_nxt, in_cmd;
  logic [DATA_WIDTH-1:0]   val_r, val_nxt;
  logic [IW-1:0]           head_r, head_nxt;
  logic [IW-1:0]           cursor_r, cursor_nxt;
  logic [IW-1:0]           free_r, free_nxt;
  logic [IW-1:0]           fresh_r, fresh_nxt;
  logic [IW-1:0]           walk_r, walk_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [VW-1:0]           out_rd_r, out_rd_nxt;
  logic                    out_act_r, out_act_nxt;
  sllc_pkg::status_t       out_status_r, out_status_nxt;

  // Link memory port controls
  logic                    nx_we, nx_re;
  logic [IW-1:0]           nx_waddr, nx_wdata, nx_raddr, nx_rdata_r, nd;
  // Value memory port controls
  logic                    vl_we, vl_re;
  logic [IW-1:0]           vl_waddr, vl_raddr;
  logic [DATA_WIDTH-1:0]   vl_wdata, vl_rdata_r;

  logic                    out_free, fin;
  logic [VW-1:0]           rd_val;
  sllc_pkg::status_t       status_v;
  logic [IW-1:0]           alloc_idx, clr_node;
  logic                    alloc_ok;

  sllc_ram #(.DEPTH(NODES), .WIDTH(IW)) u_next_ram (
    .clk     (clk),
    .we      (nx_we),
    .waddr   (nx_waddr[AW-1:0]),
    .wdata   (nx_wdata),
    .re      (nx_re),
    .raddr   (nx_raddr[AW-1:0]),
    .rdata_r (nx_rdata_r)
  );

  sllc_ram #(.DEPTH(NODES), .WIDTH(DATA_WIDTH)) u_value_ram (
    .clk     (clk),
    .we      (vl_we),
    .waddr   (vl_waddr[AW-1:0]),
    .wdata   (vl_wdata),
    .re      (vl_re),
    .raddr   (vl_raddr[AW-1:0]),
    .rdata_r (vl_rdata_r)
  );

  assign in_cmd   = sllc_pkg::cmd_t'(in_ch.cmd);
  // Link read data, any out-of-range code folded to null
  assign nd       = (nx_rdata_r < NIL) ? nx_rdata_r : NIL;
  assign out_free = !out_valid_r || out_ch.ready;

  // Allocation: free list first (its next link was read at accept), then bump counter
  always_comb begin
    alloc_ok  = 1'b1;
    alloc_idx = NIL;
    if (free_r < NIL) begin
      alloc_idx = free_r;
    end else if (fresh_r < NIL) begin
      alloc_idx = fresh_r;
    end else begin
      alloc_ok = 1'b0;
    end
  end

  // Node being released by the clear walk: head on the first step, then the walk pointer
  assign clr_node = (st_r == S_EXEC) ? head_r : walk_r;

  always_comb begin
    st_nxt         = st_r;
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    head_nxt       = head_r;
    cursor_nxt     = cursor_r;
    free_nxt       = free_r;
    fresh_nxt      = fresh_r;
    walk_nxt       = walk_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_rd_nxt     = out_rd_r;
    out_act_nxt    = out_act_r;
    out_status_nxt = out_status_r;
    nx_we          = 1'b0;
    nx_waddr       = '0;
    nx_wdata       = '0;
    nx_re          = 1'b0;
    nx_raddr       = '0;
    vl_we          = 1'b0;
    vl_waddr       = '0;
    vl_wdata       = val_r;
    vl_re          = 1'b0;
    vl_raddr       = '0;
    fin            = 1'b0;
    rd_val         = '0;
    status_v       = sllc_pkg::ST_OK;

    unique case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt = in_cmd;
          val_nxt = DATA_WIDTH'(in_ch.value);
          st_nxt  = S_EXEC;
          // Issue the first memory read now so data is back in S_EXEC
          unique case (in_cmd) inside
            sllc_pkg::CMD_CLEAR, sllc_pkg::CMD_DEL_HEAD: begin
              nx_raddr = head_r;
              nx_re    = head_r < NIL;
            end
            sllc_pkg::CMD_INS_HEAD, sllc_pkg::CMD_INS_AFTER: begin
              nx_raddr = free_r;
              nx_re    = free_r < NIL;
            end
            sllc_pkg::CMD_DEL_AFTER, sllc_pkg::CMD_ADVANCE: begin
              nx_raddr = cursor_r;
              nx_re    = cursor_r < NIL;
            end
            sllc_pkg::CMD_RD_HEAD: begin
              vl_raddr = head_r;
              vl_re    = head_r < NIL;
            end
            sllc_pkg::CMD_RD_CUR: begin
              vl_raddr = cursor_r;
              vl_re    = cursor_r < NIL;
            end
            default: ;
          endcase
        end
      end

      S_EXEC: begin
        if (out_free) begin
          case (cmd_r)
            sllc_pkg::CMD_CLEAR: begin
              if (head_r < NIL) begin
                // first clear step on the head node; shares the walk datapath
                nx_we    = 1'b1;
                nx_waddr = clr_node;
                nx_wdata = free_r;
                free_nxt = clr_node;
                if (nd < NIL) begin
                  nx_re    = 1'b1;
                  nx_raddr = nd;
                  walk_nxt = nd;
                  st_nxt   = S_CLR;
                end else begin
                  head_nxt   = NIL;
                  cursor_nxt = NIL;
                  fin        = 1'b1;
                end
              end else begin
                head_nxt   = NIL;
                cursor_nxt = NIL;
                fin        = 1'b1;
              end
            end
            sllc_pkg::CMD_INS_HEAD: begin
              if (alloc_ok) begin
                if (free_r < NIL) free_nxt = nd;
                else fresh_nxt = fresh_r + IW'(1);
                vl_we    = 1'b1;
                vl_waddr = alloc_idx;
                nx_we    = 1'b1;
                nx_waddr = alloc_idx;
                nx_wdata = head_r;
                head_nxt = alloc_idx;
              end else begin
                status_v = sllc_pkg::ST_FULL;
              end
              fin = 1'b1;
            end
            sllc_pkg::CMD_CUR_HEAD: begin
              cursor_nxt = head_r;
              fin        = 1'b1;
            end
            sllc_pkg::CMD_RD_HEAD: begin
              if (head_r < NIL) rd_val = VW'(signed'(vl_rdata_r));
              else status_v = sllc_pkg::ST_EMPTY;
              fin = 1'b1;
            end
            sllc_pkg::CMD_DEL_HEAD: begin
              if (head_r < NIL) begin
                if (cursor_r == head_r) cursor_nxt = NIL;
                head_nxt = nd;
                nx_we    = 1'b1;
                nx_waddr = head_r;
                nx_wdata = free_r;
                free_nxt = head_r;
              end
              fin = 1'b1;
            end
            sllc_pkg::CMD_DEL_AFTER: begin
              // nd is the node after the cursor; fetch its successor
              if (cursor_r < NIL && nd < NIL) begin
                nx_re    = 1'b1;
                nx_raddr = nd;
                walk_nxt = nd;
                st_nxt   = S_STEP2;
              end else begin
                fin = 1'b1;
              end
            end
            sllc_pkg::CMD_INS_AFTER: begin
              if (cursor_r < NIL) begin
                if (alloc_ok) begin
                  if (free_r < NIL) free_nxt = nd;
                  else fresh_nxt = fresh_r + IW'(1);
                  vl_we    = 1'b1;
                  vl_waddr = alloc_idx;
                  walk_nxt = alloc_idx;
                  nx_re    = 1'b1;
                  nx_raddr = cursor_r;
                  st_nxt   = S_STEP2;
                end else begin
                  status_v = sllc_pkg::ST_FULL;
                  fin      = 1'b1;
                end
              end else begin
                fin = 1'b1;
              end
            end
            sllc_pkg::CMD_RD_CUR: begin
              if (cursor_r < NIL) rd_val = VW'(signed'(vl_rdata_r));
              else status_v = sllc_pkg::ST_EMPTY;
              fin = 1'b1;
            end
            sllc_pkg::CMD_WR_CUR: begin
              if (cursor_r < NIL) begin
                vl_we    = 1'b1;
                vl_waddr = cursor_r;
              end
              fin = 1'b1;
            end
            sllc_pkg::CMD_ADVANCE: begin
              if (cursor_r < NIL) cursor_nxt = nd;
              fin = 1'b1;
            end
            default: fin = 1'b1;
          endcase
        end
      end

      S_STEP2: begin
        if (out_free) begin
          nx_we  = 1'b1;
          st_nxt = S_STEP3;
          if (cmd_r == sllc_pkg::CMD_DEL_AFTER) begin
            // unlink: cursor skips the removed node
            nx_waddr = cursor_r;
            nx_wdata = nd;
          end else begin
            // new node takes over the cursor's old successor
            nx_waddr = walk_r;
            nx_wdata = nd;
          end
        end
      end

      S_STEP3: begin
        if (out_free) begin
          nx_we = 1'b1;
          fin   = 1'b1;
          if (cmd_r == sllc_pkg::CMD_DEL_AFTER) begin
            nx_waddr = walk_r;
            nx_wdata = free_r;
            free_nxt = walk_r;
          end else begin
            nx_waddr = cursor_r;
            nx_wdata = walk_r;
          end
        end
      end

      S_CLR: begin
        if (out_free) begin
          nx_we    = 1'b1;
          nx_waddr = clr_node;
          nx_wdata = free_r;
          free_nxt = clr_node;
          if (nd < NIL) begin
            nx_re    = 1'b1;
            nx_raddr = nd;
            walk_nxt = nd;
          end else begin
            head_nxt   = NIL;
            cursor_nxt = NIL;
            fin        = 1'b1;
          end
        end
      end

      default: st_nxt = S_IDLE;
    endcase

    if (fin) begin
      out_valid_nxt  = 1'b1;
      out_rd_nxt     = rd_val;
      out_status_nxt = status_v;
      out_act_nxt    = cursor_nxt < NIL;
      st_nxt         = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      head_r      <= NIL;
      cursor_r    <= NIL;
      free_r      <= NIL;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      head_r      <= head_nxt;
      cursor_r    <= cursor_nxt;
      free_r      <= free_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    val_r        <= val_nxt;
    walk_r       <= walk_nxt;
    out_rd_r     <= out_rd_nxt;
    out_act_r    <= out_act_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ch.ready       = (st_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.is_active  = out_act_r;
  assign out_ch.status     = out_status_r;

  // Pointers never leave the pool range
  `SLLC_ASSERT_NOW(a_ptr_range, 1'b1, head_r <= NIL && cursor_r <= NIL && free_r <= NIL && fresh_r <= NIL)
  // The cursor only points into a non-empty list
  `SLLC_ASSERT_NOW(a_cursor_in_list, cursor_r < NIL, head_r < NIL)
  // A read that finds nothing leaves the cursor inactive
  `SLLC_ASSERT_NOW(a_empty_inactive, out_ch.valid && out_ch.status == sllc_pkg::ST_EMPTY, !out_ch.is_active)
  // Pool-exhausted result only with no free and no fresh node
  `SLLC_ASSERT_NOW(a_full_exhausted, out_ch.valid && out_ch.status == sllc_pkg::ST_FULL, free_r == NIL && fresh_r == NIL)
  // The clear walk always stands on a real node
  `SLLC_ASSERT_NEXT(a_clr_walk, st_nxt == S_CLR, walk_r < NIL)

endmodule

// File: sim/tb_singly_linked_list_with_cursor_unit.sv
// Self-checking testbench for the linked-list unit with cursor: random and directed commands.
`timescale 1ns / 100ps

module tb_singly_linked_list_with_cursor_unit;

  // Pool size and null index, as built into the unit by default.
  localparam int         NODES        = sllc_pkg::NODES_DEF;
  localparam logic [6:0] NIL          = 7'd64;
  // Command codes the unit does not decode; they must leave the state alone.
  localparam logic [sllc_pkg::CMD_W-1:0] CMD_SPARE_LO = 4'd11;
  localparam logic [sllc_pkg::CMD_W-1:0] CMD_SPARE_HI = 4'd15;
  localparam int         DIRECTED_CMDS = 26;
  localparam int         RANDOM_CMDS   = 1250;
  localparam int         MAX_WAIT      = 13;
  // Slowest legal run: ~1300 words, each with up to MAX_WAIT sender and MAX_WAIT receiver
  // idle cycles, plus clears of a full pool; the limit sits above it.
  localparam int         RUN_LIMIT     = 600000;
  // Longest single command (clear of a full pool) plus margin.
  localparam int         DRAIN_CYCLES  = 80;

  typedef struct {
    logic [sllc_pkg::CMD_W-1:0]          op;
    logic signed [sllc_pkg::VALUE_W-1:0] val;
    int                                  gap;   // idle cycles before this word is offered
    bit                                  hold;  // wait until every result is back first
  } list_cmd_t;

  typedef struct {
    logic signed [sllc_pkg::VALUE_W-1:0] read_value;
    logic                                is_active;
    sllc_pkg::status_t                   status;
  } list_result_t;

  logic clk = 1'b0;
  logic rst_n;

  sllc_in_if  in_ch ();
  sllc_out_if out_ch ();

  singly_linked_list_with_cursor_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the list: node pool, head, cursor, free list and bump allocator.
  // ---------------------------------------------------------------------------
  logic signed [sllc_pkg::VALUE_W-1:0] pool_value [NODES];
  logic [6:0]                          pool_next  [NODES];
  logic [6:0]                          head_ptr;
  logic [6:0]                          cur_ptr;
  logic [6:0]                          free_ptr;
  logic [6:0]                          fresh_cnt;

  list_cmd_t    cmd_backlog[$];    // words not yet offered to the unit
  list_result_t owed_results[$];   // results of accepted words, oldest first

  int   errors      = 0;
  int   cycle_count = 0;
  bit   tx_calm     = 1'b0;   // words queued while set carry no gap
  bit   rx_calm     = 1'b0;   // receiver never stalls while set
  int   send_gap    = 0;
  bit   gap_armed   = 1'b0;
  int   stall_left  = 0;
  int   res_count   = 0;
  logic cmd_taken   = 1'b0;
  logic res_taken   = 1'b0;

  // Free list first, then never-used nodes; NIL when the pool is exhausted.
  function automatic logic [6:0] grab_node();
    logic [6:0] idx;
    idx = NIL;
    if (free_ptr < NIL) begin
      idx      = free_ptr;
      free_ptr = pool_next[idx];
    end else if (fresh_cnt < NIL) begin
      idx       = fresh_cnt;
      fresh_cnt = fresh_cnt + 7'd1;
    end
    return idx;
  endfunction

  function automatic void release_node(logic [6:0] idx);
    pool_next[idx] = free_ptr;
    free_ptr       = idx;
  endfunction

  // Applies one command to the shadow list and returns the result word it owes.
  function automatic list_result_t apply_list_cmd(logic [sllc_pkg::CMD_W-1:0] op,
                                                  logic signed [sllc_pkg::VALUE_W-1:0] val);
    list_result_t r;
    logic [6:0]   n;
    logic [6:0]   m;
    int           steps;
    r.read_value = '0;
    r.status     = sllc_pkg::ST_OK;
    case (op)
      sllc_pkg::CMD_CLEAR: begin
        n     = head_ptr;
        steps = 0;
        while (n < NIL && steps < NODES) begin
          m = pool_next[n];
          release_node(n);
          n = m;
          steps++;
        end
        head_ptr = NIL;
        cur_ptr  = NIL;
      end
      sllc_pkg::CMD_INS_HEAD: begin
        n = grab_node();
        if (n >= NIL) begin
          r.status = sllc_pkg::ST_FULL;
        end else begin
          pool_value[n] = val;
          pool_next[n]  = head_ptr;
          head_ptr      = n;
        end
      end
      sllc_pkg::CMD_CUR_HEAD: cur_ptr = head_ptr;
      sllc_pkg::CMD_RD_HEAD: begin
        if (head_ptr < NIL) r.read_value = pool_value[head_ptr];
        else r.status = sllc_pkg::ST_EMPTY;
      end
      sllc_pkg::CMD_DEL_HEAD: begin
        if (head_ptr < NIL) begin
          // Cursor sitting on the removed node goes inactive.
          if (cur_ptr == head_ptr) cur_ptr = NIL;
          n        = head_ptr;
          head_ptr = pool_next[n];
          release_node(n);
        end
      end
      sllc_pkg::CMD_DEL_AFTER: begin
        if (cur_ptr < NIL) begin
          n = pool_next[cur_ptr];
          if (n < NIL) begin
            pool_next[cur_ptr] = pool_next[n];
            release_node(n);
          end
        end
      end
      sllc_pkg::CMD_INS_AFTER: begin
        // Inactive cursor: no allocation at all, so no full status either.
        if (cur_ptr < NIL) begin
          n = grab_node();
          if (n >= NIL) begin
            r.status = sllc_pkg::ST_FULL;
          end else begin
            pool_value[n]      = val;
            pool_next[n]       = pool_next[cur_ptr];
            pool_next[cur_ptr] = n;
          end
        end
      end
      sllc_pkg::CMD_RD_CUR: begin
        if (cur_ptr < NIL) r.read_value = pool_value[cur_ptr];
        else r.status = sllc_pkg::ST_EMPTY;
      end
      sllc_pkg::CMD_WR_CUR: begin
        if (cur_ptr < NIL) pool_value[cur_ptr] = val;
      end
      sllc_pkg::CMD_ADVANCE: begin
        if (cur_ptr < NIL) cur_ptr = pool_next[cur_ptr];
      end
      default: ;  // query and spare codes change nothing
    endcase
    r.is_active = (cur_ptr < NIL);
    return r;
  endfunction

  function automatic void queue_cmd(logic [sllc_pkg::CMD_W-1:0] op,
                                    logic signed [sllc_pkg::VALUE_W-1:0] val, bit hold);
    list_cmd_t c;
    c.op   = op;
    c.val  = val;
    c.gap  = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
    c.hold = hold;
    cmd_backlog.push_back(c);
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: changes inputs on the falling edge. A word stays up until
  // it is taken; the next one may follow with no gap.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    list_cmd_t nxt;
    if (!rst_n) begin
      in_ch.valid = 1'b0;
      in_ch.cmd   = sllc_pkg::CMD_QUERY;
      in_ch.value = '0;
    end else if (!in_ch.valid || cmd_taken) begin
      if (!gap_armed && cmd_backlog.size() > 0) begin
        send_gap  = cmd_backlog[0].gap;
        gap_armed = 1'b1;
      end
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid = 1'b0;
      end else if (gap_armed && !(cmd_backlog[0].hold && owed_results.size() != 0)) begin
        nxt         = cmd_backlog.pop_front();
        gap_armed   = 1'b0;
        in_ch.cmd   = nxt.op;
        in_ch.value = nxt.val;
        in_ch.valid = 1'b1;
      end else begin
        in_ch.valid = 1'b0;
      end
    end
  end

  // Result sink: after each word taken, draw a fresh stall before ready returns.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
    end else begin
      if (res_taken) begin
        res_count++;
        if (res_count % 48 == 0) rx_calm = ($urandom_range(0, 2) == 0);
        stall_left = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ch.ready = (stall_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: samples both handshakes on the rising edge. Results are checked
  // before the new command is predicted; a word may be taken while a result waits.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    list_result_t want;
    cmd_taken <= in_ch.valid && in_ch.ready;
    res_taken <= out_ch.valid && out_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: unexpected result word read_value=%0d is_active=%0b status=%0d",
                 $time, out_ch.read_value, out_ch.is_active, out_ch.status);
        errors++;
      end else begin
        want = owed_results.pop_front();
        if (out_ch.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d actual %0d",
                   $time, want.read_value, out_ch.read_value);
          errors++;
        end
        if (out_ch.is_active !== want.is_active) begin
          $display("%0t: is_active expected %0b actual %0b",
                   $time, want.is_active, out_ch.is_active);
          errors++;
        end
        if (out_ch.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, want.status, out_ch.status);
          errors++;
        end
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      owed_results.push_back(apply_list_cmd(in_ch.cmd, in_ch.value));
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("singly_linked_list_with_cursor_unit regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    int                         seg;
    int                         len;
    int                         r;
    logic [sllc_pkg::CMD_W-1:0] op;

    rst_n = 1'b0;

    head_ptr  = NIL;
    cur_ptr   = NIL;
    free_ptr  = NIL;
    fresh_cnt = '0;
    for (int i = 0; i < NODES; i++) begin
      pool_value[i] = '0;
      pool_next[i]  = NIL;
    end

    // Directed: every command but insert at head and query on an empty list first
    // (reads report empty, the rest do nothing), then value extremes and cursor corner cases.
    queue_cmd(sllc_pkg::CMD_RD_HEAD, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_RD_CUR, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_DEL_HEAD, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_CUR_HEAD, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_INS_AFTER, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_WR_CUR, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_ADVANCE, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_DEL_AFTER, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_CLEAR, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_INS_HEAD, 32'sh7FFF_FFFF, 1'b0);
    queue_cmd(sllc_pkg::CMD_INS_HEAD, 32'sh8000_0000, 1'b0);
    queue_cmd(sllc_pkg::CMD_INS_HEAD, 32'sh0000_0000, 1'b0);
    queue_cmd(sllc_pkg::CMD_INS_HEAD, 32'shFFFF_FFFF, 1'b0);
    queue_cmd(sllc_pkg::CMD_RD_HEAD, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_CUR_HEAD, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_INS_AFTER, 32'sh5555_5555, 1'b0);
    queue_cmd(sllc_pkg::CMD_ADVANCE, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_WR_CUR, 32'shAAAA_AAAA, 1'b0);
    queue_cmd(sllc_pkg::CMD_RD_CUR, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_DEL_AFTER, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_QUERY, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_CUR_HEAD, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_DEL_HEAD, $urandom, 1'b0);   // removes the node under the cursor
    queue_cmd(CMD_SPARE_LO, $urandom, 1'b0);
    queue_cmd(CMD_SPARE_HI, $urandom, 1'b0);
    queue_cmd(sllc_pkg::CMD_CLEAR, $urandom, 1'b0);

    // First random word waits for an empty pipeline.
    queue_cmd(sllc_pkg::CMD_QUERY, $urandom, 1'b1);

    // Random part in segments: mixed traffic, pool fills up to exhaustion,
    // cursor walks over a grown list, drain pauses and clears.
    while (cmd_backlog.size() < DIRECTED_CMDS + RANDOM_CMDS) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      seg     = $urandom_range(0, 9);
      if (seg <= 3) begin
        len = $urandom_range(10, 40);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 3) op = sllc_pkg::CMD_CLEAR;
          else if (r < 22) op = sllc_pkg::CMD_INS_HEAD;
          else if (r < 30) op = sllc_pkg::CMD_CUR_HEAD;
          else if (r < 36) op = sllc_pkg::CMD_RD_HEAD;
          else if (r < 44) op = sllc_pkg::CMD_DEL_HEAD;
          else if (r < 52) op = sllc_pkg::CMD_DEL_AFTER;
          else if (r < 66) op = sllc_pkg::CMD_INS_AFTER;
          else if (r < 74) op = sllc_pkg::CMD_RD_CUR;
          else if (r < 80) op = sllc_pkg::CMD_WR_CUR;
          else if (r < 90) op = sllc_pkg::CMD_ADVANCE;
          else if (r < 96) op = sllc_pkg::CMD_QUERY;
          else begin
            r  = $urandom_range(CMD_SPARE_LO, CMD_SPARE_HI);
            op = r[sllc_pkg::CMD_W-1:0];
          end
          queue_cmd(op, $urandom, 1'b0);
        end
      end else if (seg <= 5) begin
        // More inserts than the pool holds: the tail of the burst hits full.
        queue_cmd(sllc_pkg::CMD_INS_HEAD, $urandom, 1'b0);
        queue_cmd(sllc_pkg::CMD_CUR_HEAD, $urandom, 1'b0);
        repeat (NODES + 6) begin
          op = $urandom_range(0, 1) ? sllc_pkg::CMD_INS_HEAD : sllc_pkg::CMD_INS_AFTER;
          queue_cmd(op, $urandom, 1'b0);
        end
        queue_cmd(sllc_pkg::CMD_RD_HEAD, $urandom, 1'b0);
        queue_cmd(sllc_pkg::CMD_RD_CUR, $urandom, 1'b0);
        if ($urandom_range(0, 1)) queue_cmd(sllc_pkg::CMD_CLEAR, $urandom, 1'b0);
      end else if (seg <= 7) begin
        queue_cmd(sllc_pkg::CMD_CUR_HEAD, $urandom, 1'b0);
        len = $urandom_range(20, 60);
        repeat (len) begin
          case ($urandom_range(0, 9))
            0, 1, 2: op = sllc_pkg::CMD_ADVANCE;
            3:       op = sllc_pkg::CMD_RD_CUR;
            4:       op = sllc_pkg::CMD_WR_CUR;
            5:       op = sllc_pkg::CMD_DEL_AFTER;
            6, 7:    op = sllc_pkg::CMD_INS_AFTER;
            8:       op = sllc_pkg::CMD_QUERY;
            default: op = sllc_pkg::CMD_CUR_HEAD;
          endcase
          queue_cmd(op, $urandom, 1'b0);
        end
      end else if (seg == 8) begin
        queue_cmd(sllc_pkg::CMD_QUERY, $urandom, 1'b1);
        queue_cmd(sllc_pkg::CMD_RD_HEAD, $urandom, 1'b0);
      end else begin
        queue_cmd(sllc_pkg::CMD_CLEAR, $urandom, 1'b0);
        len = $urandom_range(1, 8);
        repeat (len) queue_cmd(sllc_pkg::CMD_INS_HEAD, $urandom, 1'b0);
      end
    end
    tx_calm = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (cmd_backlog.size() != 0 || in_ch.valid || owed_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("singly_linked_list_with_cursor_unit regression: pass");
    end else begin
      $display("singly_linked_list_with_cursor_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: singly_linked_list_with_cursor_unit.f
+incdir+design
design/sllc_pkg.sv
design/sllc_in_if.sv
design/sllc_out_if.sv
design/sllc_ram.sv
design/singly_linked_list_with_cursor_unit.sv
sim/tb_singly_linked_list_with_cursor_unit.sv
